### hdl/srrb_pkg.sv
// ----------------------------------------------------------------------------
// srrb_pkg
// Shared types and constants of the slotted record ring buffer.
// ----------------------------------------------------------------------------
package srrb_pkg;

	localparam int DEF_SLOTS      = 8;
	localparam int DEF_SLOT_BYTES = 256;

	typedef enum logic [1:0] {
		OP_OPEN    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_READ    = 2'd2,
		OP_ADVANCE = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic len_rd;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

### hdl/srrb_if.sv
// ----------------------------------------------------------------------------
// srrb_if
// Request and response channels of the slotted record ring buffer.
// ----------------------------------------------------------------------------
interface srrb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] record_length;
	logic [7:0] data_byte;
	logic [7:0] byte_offset;

	modport source (output valid, op, record_length, data_byte, byte_offset, input ready);
	modport sink (input valid, op, record_length, data_byte, byte_offset, output ready);
endinterface

interface srrb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] stored_length;
	logic [7:0] read_byte;
	logic       record_present;

	modport source (output valid, stored_length, read_byte, record_present, input ready);
	modport sink (input valid, stored_length, read_byte, record_present, output ready);
endinterface

### hdl/slotted_record_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// slotted_record_ring_buffer_unit
// Ring of fixed-size record slots with length headers and data bytes.
// ----------------------------------------------------------------------------
//  channel  role    payload
//  req      sink    op, record_length, data_byte, byte_offset
//  rsp      source  stored_length, read_byte, record_present
//
//  One request at a time: accept edge, execute (pointer update, memory
//  write or read), length read, result load.
//  The single-port data memory and the registered length read set these steps.
//  A held result stalls the sequencer in its last step; the request side
//  stays closed until that result is taken.
//  Reset clears pointers and length valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module slotted_record_ring_buffer_unit #(
	parameter int SLOTS      = srrb_pkg::DEF_SLOTS,
	parameter int SLOT_BYTES = srrb_pkg::DEF_SLOT_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	srrb_req_if.sink   req,
	srrb_rsp_if.source rsp
);
	import srrb_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;
	logic     in_ready;

	assign req.ready = in_ready;

	srrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srrb_dp #(
		.SLOTS      (SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

### hdl/srrb_ctrl.sv
// ----------------------------------------------------------------------------
// srrb_ctrl
// Sequencer: accept one request, run it through the datapath, load the result.
// ----------------------------------------------------------------------------
module srrb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  srrb_pkg::dp_sts_t sts,
	output srrb_pkg::ctl_cmd_t cmd
);
	import srrb_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LEN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   rdy_q;

	assign in_ready     = rdy_q;
	assign cmd.load     = in_valid && rdy_q;
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.len_rd   = (state_q == S_LEN);
	assign cmd.out_load = (state_q == S_DONE) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && rdy_q) begin
						state_q <= S_EXEC;
						rdy_q   <= 1'b0;
					end
				end
				S_EXEC: begin
					state_q <= S_LEN;
				end
				S_LEN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

endmodule

### hdl/srrb_dp.sv
// ----------------------------------------------------------------------------
// srrb_dp
// Datapath: slot pointers, length store, data byte memory, result register.
// ----------------------------------------------------------------------------
module srrb_dp #(
	parameter int SLOTS      = srrb_pkg::DEF_SLOTS,
	parameter int SLOT_BYTES = srrb_pkg::DEF_SLOT_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  srrb_pkg::ctl_cmd_t cmd,
	output srrb_pkg::dp_sts_t  sts,
	srrb_req_if.sink           req,
	srrb_rsp_if.source         rsp
);
	import srrb_pkg::*;

	localparam int SW        = $clog2(SLOTS);
	localparam int OW        = $clog2(SLOT_BYTES);
	localparam int AW        = SW + OW;
	localparam int MEM_DEPTH = SLOTS << OW;
	localparam logic [7:0] DataLast = 8'(SLOT_BYTES - 1);
	localparam logic [SW-1:0] SlotLast = SW'(SLOTS - 1);

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		next_slot = (s == SlotLast) ? '0 : s + SW'(1);
	endfunction

	op_t        op_q;
	logic [7:0] len_in_q;
	logic [7:0] data_q;
	logic [7:0] off_q;

	logic [SW-1:0] wr_slot_q;
	logic [SW-1:0] rd_slot_q;
	logic [SW-1:0] fill_slot_q;

	logic [7:0]       len_mem [SLOTS];
	logic [SLOTS-1:0] len_vld_q;
	logic [7:0]       len_rd_q;
	logic             vld_rd_q;
	logic             len_we;
	logic [SW-1:0]    len_waddr;
	logic [7:0]       len_wdata;
	logic [7:0]       len_eff;

	logic [7:0]    data_mem [MEM_DEPTH];
	logic [7:0]    data_rd_q;
	logic          data_we;
	logic          data_re;
	logic [AW-1:0] data_addr;
	logic [7:0]    rbyte;

	logic       out_vld_q;
	logic [7:0] out_len_q;
	logic [7:0] out_byte_q;
	logic       out_pres_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(req.op);
			len_in_q <= req.record_length;
			data_q   <= req.data_byte;
			off_q    <= req.byte_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q   <= '0;
			rd_slot_q   <= '0;
			fill_slot_q <= '0;
		end else if (cmd.exec) begin
			case (op_q)
				OP_OPEN: begin
					fill_slot_q <= wr_slot_q;
					wr_slot_q   <= next_slot(wr_slot_q);
				end
				OP_ADVANCE: begin
					rd_slot_q <= next_slot(rd_slot_q);
				end
				default: begin
				end
			endcase
		end
	end

	assign len_we    = cmd.exec && (op_q == OP_OPEN || op_q == OP_ADVANCE);
	assign len_waddr = (op_q == OP_OPEN) ? wr_slot_q : rd_slot_q;
	assign len_wdata = (op_q == OP_OPEN) ? len_in_q : 8'd0;

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		if (cmd.len_rd) begin
			len_rd_q <= len_mem[rd_slot_q];
			vld_rd_q <= len_vld_q[rd_slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (len_we) begin
			len_vld_q[len_waddr] <= 1'b1;
		end
	end

	assign len_eff = vld_rd_q ? len_rd_q : 8'd0;

	assign data_we   = cmd.exec && (op_q == OP_WRITE) && (off_q < DataLast);
	assign data_re   = cmd.exec && (op_q == OP_READ);
	assign data_addr = (op_q == OP_WRITE) ? {fill_slot_q, off_q[OW-1:0]}
	                                      : {rd_slot_q, off_q[OW-1:0]};

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_addr] <= data_q;
		end
		if (data_re) begin
			data_rd_q <= data_mem[data_addr];
		end
	end

	assign rbyte = ((op_q == OP_READ) && (off_q < DataLast) && (off_q < len_eff))
	               ? data_rd_q : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_len_q  <= len_eff;
			out_byte_q <= rbyte;
			out_pres_q <= (len_eff != 8'd0);
		end
	end

	assign sts.out_free       = !out_vld_q || rsp.ready;
	assign rsp.valid          = out_vld_q;
	assign rsp.stored_length  = out_len_q;
	assign rsp.read_byte      = out_byte_q;
	assign rsp.record_present = out_pres_q;

endmodule

### hdl/srrb_checker.sv
// ----------------------------------------------------------------------------
// srrb_checker
// Port-level checks of the slotted record ring buffer.
// ----------------------------------------------------------------------------
module srrb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] stored_length,
	input logic [7:0] read_byte,
	input logic       record_present
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stored_length)
		&& $stable(read_byte) && $stable(record_present))
		else $error("result changed while stalled");

	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_present == (stored_length != 8'd0)))
		else $error("record_present disagrees with stored_length");

	a_empty_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_present |-> read_byte == 8'd0)
		else $error("data byte returned from empty slot");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a request in flight");

endmodule

bind slotted_record_ring_buffer_unit srrb_checker u_srrb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.stored_length  (rsp.stored_length),
	.read_byte      (rsp.read_byte),
	.record_present (rsp.record_present)
);

### test/srrb_status_checker.sv
// ----------------------------------------------------------------------------
// srrb_status_checker
// Watches both channels of the slotted record ring buffer, predicts the
// status of every accepted request from its own copy of the ring and
// compares each response field by field, in order.
// ----------------------------------------------------------------------------
module srrb_status_checker (
	input  logic clk,
	input  logic arst_n,
	srrb_req_if  req,
	srrb_rsp_if  rsp,
	output int   mismatches,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import srrb_pkg::*;

	localparam int NSLOT      = DEF_SLOTS;
	localparam int DATA_BYTES = DEF_SLOT_BYTES - 1;
	localparam int SW         = $clog2(NSLOT);

	typedef struct packed {
		logic [7:0] stored_length;
		logic [7:0] read_byte;
		logic       record_present;
	} ring_status_t;

	logic [7:0]   hdr_len [NSLOT];
	logic [7:0]   rec_data [NSLOT][DATA_BYTES];
	logic [SW-1:0] wr_slot, rd_slot, fill_slot;
	ring_status_t status_q [$];
	ring_status_t want;
	int           n_results;

	function automatic logic [SW-1:0] next_slot(logic [SW-1:0] s);
		return (s == SW'(NSLOT - 1)) ? '0 : s + SW'(1);
	endfunction

	function automatic ring_status_t step_ring(op_t op, logic [7:0] len, logic [7:0] data,
		logic [7:0] off);
		ring_status_t st;
		st.read_byte = 8'h00;
		case (op)
			OP_OPEN: begin
				hdr_len[wr_slot] = len;
				fill_slot        = wr_slot;
				wr_slot          = next_slot(wr_slot);
			end
			OP_WRITE: begin
				if (off < DATA_BYTES)
					rec_data[fill_slot][off] = data;
			end
			OP_READ: begin
				if (off < DATA_BYTES && off < hdr_len[rd_slot])
					st.read_byte = rec_data[rd_slot][off];
			end
			default: begin
				hdr_len[rd_slot] = 8'h00;
				rd_slot          = next_slot(rd_slot);
			end
		endcase
		st.stored_length  = hdr_len[rd_slot];
		st.record_present = (hdr_len[rd_slot] != 8'h00);
		return st;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns  result %0d: %s", $time, n_results, msg);
		mismatches++;
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++)
				hdr_len[i] = 8'h00;
			wr_slot   = '0;
			rd_slot   = '0;
			fill_slot = '0;
			n_results = 0;
			status_q.delete();
			pending   = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					report_mismatch("response transfer with no request outstanding");
				end else begin
					want = status_q.pop_front();
					if (rsp.stored_length !== want.stored_length)
						report_mismatch($sformatf("stored_length %02h, expected %02h",
							rsp.stored_length, want.stored_length));
					if (rsp.read_byte !== want.read_byte)
						report_mismatch($sformatf("read_byte %02h, expected %02h",
							rsp.read_byte, want.read_byte));
					if (rsp.record_present !== want.record_present)
						report_mismatch($sformatf("record_present %b, expected %b",
							rsp.record_present, want.record_present));
				end
				n_results++;
			end
			if (req.valid && req.ready)
				status_q.push_back(step_ring(op_t'(req.op), req.record_length,
					req.data_byte, req.byte_offset));
			pending = status_q.size();
		end
	end

endmodule

### test/slotted_record_ring_buffer_unit_tb.sv
// ----------------------------------------------------------------------------
// slotted_record_ring_buffer_unit_tb
// Drives directed and random request sequences into the ring buffer under
// several idle and stall mixes, lets the status checker compare every
// response, and reports the verdict.
// ----------------------------------------------------------------------------
module slotted_record_ring_buffer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srrb_pkg::*;

	localparam int NSLOT            = DEF_SLOTS;
	localparam int DATA_BYTES       = DEF_SLOT_BYTES - 1;
	localparam int IDLE_LIMIT       = 2000;
	localparam int RANDOM_PER_PHASE = 210;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	srrb_req_if req_ch ();
	srrb_rsp_if rsp_ch ();

	int mismatches, pending;
	int send_idle_pct, recv_stall_pct;
	int idle_cycles;

	// stimulus-side view of the ring, used to pick read offsets and to count hits and wraps
	int  sim_len [NSLOT];
	bit  byte_written [NSLOT][DATA_BYTES];
	int  wr_ptr, rd_ptr, fill_ptr;
	int  n_items, n_hits, n_wraps;
	int  op_cnt [4];

	always #5 clk = ~clk;

	slotted_record_ring_buffer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	srrb_status_checker status_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic issue(op_t op, logic [7:0] len, logic [7:0] data, logic [7:0] off);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.op            <= op;
		req_ch.record_length <= len;
		req_ch.data_byte     <= data;
		req_ch.byte_offset   <= off;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		case (op)
			OP_OPEN: begin
				sim_len[wr_ptr] = len;
				fill_ptr        = wr_ptr;
				if (wr_ptr == NSLOT - 1) begin
					wr_ptr = 0;
					n_wraps++;
				end else begin
					wr_ptr++;
				end
			end
			OP_WRITE: begin
				if (off < DATA_BYTES)
					byte_written[fill_ptr][off] = 1'b1;
			end
			OP_READ: begin
				if (off < DATA_BYTES && off < sim_len[rd_ptr])
					n_hits++;
			end
			default: begin
				sim_len[rd_ptr] = 0;
				rd_ptr          = (rd_ptr == NSLOT - 1) ? 0 : rd_ptr + 1;
			end
		endcase
		n_items++;
		op_cnt[op]++;
	endtask

	// written byte inside the record, or any offset past its header
	function automatic logic [7:0] pick_read_offset();
		int cap, off;
		cap = (sim_len[rd_ptr] > DATA_BYTES) ? DATA_BYTES : sim_len[rd_ptr];
		repeat (6) begin
			if (cap > 0) begin
				off = $urandom_range(cap - 1);
				if (byte_written[rd_ptr][off])
					return off[7:0];
			end
		end
		if (sim_len[rd_ptr] < 255)
			return 8'($urandom_range(255, sim_len[rd_ptr]));
		return 8'd255;
	endfunction

	task automatic fill_record();
		int r, len, cap;
		r   = $urandom_range(99);
		len = (r < 75) ? $urandom_range(12, 1) :
			(r < 95) ? $urandom_range(64, 13) : $urandom_range(255, 65);
		issue(OP_OPEN, len[7:0], 8'($urandom), 8'($urandom));
		if (len <= 12) begin
			for (int k = 0; k < len; k++)
				issue(OP_WRITE, 8'($urandom), 8'($urandom), k[7:0]);
		end else begin
			cap = (len > DATA_BYTES) ? DATA_BYTES : len;
			repeat ($urandom_range(12, 4))
				issue(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom_range(cap - 1)));
		end
	endtask

	task automatic drain_record();
		repeat ($urandom_range(4))
			issue(OP_READ, 8'($urandom), 8'($urandom), pick_read_offset());
		issue(OP_ADVANCE, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic noise_item();
		op_t op;
		op = op_t'($urandom_range(3));
		if (op == OP_READ)
			issue(op, 8'($urandom), 8'($urandom), pick_read_offset());
		else
			issue(op, 8'($urandom), 8'($urandom), 8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int send_mix [4];
		int recv_mix [4];
		int target, r;
		send_mix = '{0, 71, 0, 14};
		recv_mix = '{0, 0, 71, 14};
		req_ch.valid         = 1'b0;
		req_ch.op            = OP_READ;
		req_ch.record_length = 8'h00;
		req_ch.data_byte     = 8'h00;
		req_ch.byte_offset   = 8'h00;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		idle_cycles          = 0;
		wr_ptr = 0;
		rd_ptr = 0;
		fill_ptr = 0;
		n_items = 0;
		n_hits = 0;
		n_wraps = 0;
		op_cnt = '{0, 0, 0, 0};
		for (int s = 0; s < NSLOT; s++)
			sim_len[s] = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty ring, write before open, out-of-range write, offset extremes
		issue(OP_READ,    8'h00, 8'h00, 8'd0);
		issue(OP_WRITE,   8'h00, 8'hA5, 8'd3);
		issue(OP_WRITE,   8'hFF, 8'hFF, 8'd255);
		issue(OP_WRITE,   8'h00, 8'h00, 8'd0);
		issue(OP_WRITE,   8'h00, 8'hFF, 8'd254);
		// full-length header, reads inside and past the slot
		issue(OP_OPEN,    8'd255, 8'h00, 8'h00);
		issue(OP_READ,    8'h00, 8'h00, 8'd3);
		issue(OP_READ,    8'h00, 8'h00, 8'd0);
		issue(OP_READ,    8'hFF, 8'hFF, 8'd254);
		issue(OP_READ,    8'h00, 8'h00, 8'd255);
		// zero-length record, advance over full and empty slots
		issue(OP_OPEN,    8'd0, 8'hFF, 8'hFF);
		issue(OP_WRITE,   8'h00, 8'h5A, 8'd0);
		issue(OP_ADVANCE, 8'h00, 8'h00, 8'h00);
		issue(OP_READ,    8'h00, 8'h00, 8'd0);
		issue(OP_ADVANCE, 8'hFF, 8'hFF, 8'hFF);
		// one-byte record, read at and past its end
		issue(OP_OPEN,    8'd1, 8'h00, 8'h00);
		issue(OP_WRITE,   8'h00, 8'hC3, 8'd0);
		issue(OP_READ,    8'h00, 8'h00, 8'd0);
		issue(OP_READ,    8'h00, 8'h00, 8'd1);
		issue(OP_ADVANCE, 8'h00, 8'h00, 8'h00);
		issue(OP_ADVANCE, 8'h00, 8'h00, 8'h00);

		for (int p = 0; p < 4; p++) begin
			// hold the sender until every response is back
			req_ch.valid <= 1'b0;
			wait_drained();
			send_idle_pct  = send_mix[p];
			recv_stall_pct = recv_mix[p];
			target = n_items + RANDOM_PER_PHASE;
			while (n_items < target) begin
				r = $urandom_range(99);
				if (r < 35)
					fill_record();
				else if (r < 65)
					drain_record();
				else
					noise_item();
			end
		end
		req_ch.valid <= 1'b0;
		wait_drained();
		repeat (20) @(negedge clk);

		$display("Covered %0d requests: %0d open, %0d write, %0d read, %0d advance",
			n_items, op_cnt[OP_OPEN], op_cnt[OP_WRITE], op_cnt[OP_READ], op_cnt[OP_ADVANCE]);
		$display("%0d reads inside a record, %0d wraps of the write slot, %0d mismatches",
			n_hits, n_wraps, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
hdl/srrb_pkg.sv
hdl/srrb_if.sv
hdl/srrb_ctrl.sv
hdl/srrb_dp.sv
hdl/slotted_record_ring_buffer_unit.sv
hdl/srrb_checker.sv
test/srrb_status_checker.sv
test/slotted_record_ring_buffer_unit_tb.sv
